FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Implication checked on the following clock edge.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/mre_pkg.sv
// Types, constants and helpers of the Mooney-Rivlin energy unit.
package mre_pkg;

    localparam int IN_BITS       = 32;
    localparam int COEF_BITS     = 32;
    localparam int OUT_BITS      = 48;
    localparam int NUM_GRAD      = 9;
    localparam int LIMB_BITS     = 32;
    localparam int MUL_LAT       = 4;
    // cube root: 28 result bits, three radicand bits per step
    localparam int ROOT_BITS     = 28;
    localparam int ROOT_X_BITS   = 3 * ROOT_BITS;
    localparam int ROOT_SQ_BITS  = 2 * ROOT_BITS;
    localparam int ROOT_REM_BITS = 62;
    // entries of C are kept in 64 bits
    localparam int C_BITS        = 64;
    localparam int I1_BITS       = C_BITS + 2;
    localparam int P_BITS        = 2 * C_BITS + 2;
    // I2 - 3 is capped to +/- 2^95
    localparam int CAP_EXP       = 95;
    localparam int I2C_BITS      = CAP_EXP + 2;
    localparam int NUM_PAIRS     = 6;
    localparam int CFG_IDX_BITS  = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_FIRST  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_SECOND = 8'd1;

    // upper triangle of C: 00 01 02 11 12 22
    localparam int PAIR_ROW [NUM_PAIRS] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_COL [NUM_PAIRS] = '{0, 1, 2, 1, 2, 2};
    // minor products, even index added, odd subtracted
    localparam int MINOR_A [NUM_PAIRS] = '{0, 1, 0, 2, 3, 4};
    localparam int MINOR_B [NUM_PAIRS] = '{3, 1, 5, 2, 5, 4};

    typedef struct packed {
        logic signed [IN_BITS-1:0] grad_xx;
        logic signed [IN_BITS-1:0] grad_xy;
        logic signed [IN_BITS-1:0] grad_xz;
        logic signed [IN_BITS-1:0] grad_yx;
        logic signed [IN_BITS-1:0] grad_yy;
        logic signed [IN_BITS-1:0] grad_yz;
        logic signed [IN_BITS-1:0] grad_zx;
        logic signed [IN_BITS-1:0] grad_zy;
        logic signed [IN_BITS-1:0] grad_zz;
        logic signed [IN_BITS-1:0] volume_ratio;
    } mre_request_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] energy_density;
        logic                       zero_volume;
    } mre_result_t;

    // start-to-result latency in cycles
    function automatic int pipe_latency(input int frac_bits);
        return IN_BITS + frac_bits + ROOT_BITS + 3 * MUL_LAT + 6;
    endfunction

endpackage

FILE: rtl/mre_mul.sv
// Pipelined signed multiplier built from 32x32 limb products.
module mre_mul
    import mre_pkg::*;
#(
    parameter int A_BITS = 64,
    parameter int B_BITS = 64
) (
    input  logic                             clk,
    input  logic signed [A_BITS-1:0]         a,
    input  logic signed [B_BITS-1:0]         b,
    output logic signed [A_BITS+B_BITS-1:0]  p
);

    localparam int A_LIMBS = (A_BITS + LIMB_BITS - 1) / LIMB_BITS;
    localparam int B_LIMBS = (B_BITS + LIMB_BITS - 1) / LIMB_BITS;
    localparam int A_PAD   = A_LIMBS * LIMB_BITS;
    localparam int B_PAD   = B_LIMBS * LIMB_BITS;
    localparam int S_BITS  = A_PAD + B_PAD;
    localparam int P_BITS  = A_BITS + B_BITS;

    logic [A_BITS-1:0]        a_abs;
    logic [B_BITS-1:0]        b_abs;
    logic [A_PAD-1:0]         a_mag_reg;
    logic [B_PAD-1:0]         b_mag_reg;
    logic                     neg1_reg, neg2_reg, neg3_reg;
    logic [2*LIMB_BITS-1:0]   pp_reg [A_LIMBS][B_LIMBS];
    logic [S_BITS-1:0]        acc;
    logic [S_BITS-1:0]        acc_reg;
    logic signed [P_BITS-1:0] p_reg;

    // stage 1: magnitudes and product sign
    assign a_abs = a[A_BITS-1] ? (A_BITS'(~a) + A_BITS'(1)) : A_BITS'(a);
    assign b_abs = b[B_BITS-1] ? (B_BITS'(~b) + B_BITS'(1)) : B_BITS'(b);

    always_ff @(posedge clk)
    begin
        a_mag_reg <= A_PAD'(a_abs);
        b_mag_reg <= B_PAD'(b_abs);
        neg1_reg  <= a[A_BITS-1] ^ b[B_BITS-1];
    end

    // stage 2: limb products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < A_LIMBS; i++)
        begin
            for (int j = 0; j < B_LIMBS; j++)
            begin
                pp_reg[i][j] <= a_mag_reg[i*LIMB_BITS +: LIMB_BITS]
                              * b_mag_reg[j*LIMB_BITS +: LIMB_BITS];
            end
        end
        neg2_reg <= neg1_reg;
    end

    // stage 3: align and add the limb products
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < A_LIMBS; i++)
        begin
            for (int j = 0; j < B_LIMBS; j++)
            begin
                acc = acc + (S_BITS'(pp_reg[i][j]) << (LIMB_BITS * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc;
        neg3_reg <= neg2_reg;
    end

    // stage 4: restore the sign
    always_ff @(posedge clk)
    begin
        p_reg <= neg3_reg ? (P_BITS'(0) - P_BITS'(acc_reg)) : P_BITS'(acc_reg);
    end

    assign p = p_reg;

endmodule

FILE: rtl/mooney_rivlin_energy_unit.sv
// Top level: pipelined Mooney-Rivlin strain energy density unit.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-----------------------------------
//  request   | start / busy             | request  (gradient 3x3, J)
//  result    | result_valid (1 cycle)   | result   (energy_density, zero_volume)
//  config    | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One request per cycle while busy is low; on its way to the result a request
// passes 28 cube-root steps, 32 + FRAC_BITS divider steps, three multipliers
// in series and six further registers (input, sign, sums, cap, saturation).
// busy and cfg_ready are low/high from the cycle after reset release.
// The result side has no backpressure, so the pipeline never stalls.
module mooney_rivlin_energy_unit
    import mre_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  mre_request_t             request,
    output logic                     result_valid,
    output mre_result_t              result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [COEF_BITS-1:0]     cfg_data
);

    localparam int NUM_BITS    = IN_BITS + FRAC_BITS;
    localparam int G_BITS      = NUM_BITS + 1;
    localparam int PROD_G_BITS = 2 * G_BITS;
    localparam int CS_BITS     = PROD_G_BITS + 2;
    localparam int T1_BITS     = COEF_BITS + I1_BITS;
    localparam int T2_BITS     = COEF_BITS + I2C_BITS;
    localparam int W_BITS      = T2_BITS + 1;
    localparam int LAT         = pipe_latency(FRAC_BITS);

    localparam logic signed [P_BITS-1:0]  THREE_P  = P_BITS'(3) << FRAC_BITS;
    localparam logic signed [I1_BITS-1:0] THREE_I1 = I1_BITS'(3) << FRAC_BITS;
    localparam logic signed [P_BITS-1:0]  CAP_HI   = P_BITS'(1) << CAP_EXP;
    localparam logic signed [P_BITS-1:0]  CAP_LO   = -CAP_HI;
    localparam logic signed [W_BITS-1:0]  OUT_MAX  = (W_BITS'(1) << (OUT_BITS - 1)) - 1;
    localparam logic signed [W_BITS-1:0]  OUT_MIN  = -(W_BITS'(1) << (OUT_BITS - 1));

    // control
    logic                 busy_reg;
    logic                 accept;
    logic [COEF_BITS-1:0] coef_first_reg, coef_first_next;
    logic [COEF_BITS-1:0] coef_second_reg, coef_second_next;
    logic [LAT-1:0]       vld_reg;
    logic [LAT-1:0]       zero_reg;

    // input stage
    logic signed [IN_BITS-1:0] grad_in [NUM_GRAD];
    logic [IN_BITS-1:0]        j_mag;
    logic [IN_BITS-1:0]        in_fmag_reg [NUM_GRAD];
    logic                      in_fneg_reg [NUM_GRAD];
    logic [ROOT_X_BITS-1:0]    in_x_reg;

    // cube root stages
    logic [ROOT_BITS-1:0]     cr_y_reg   [ROOT_BITS];
    logic [ROOT_SQ_BITS-1:0]  cr_s_reg   [ROOT_BITS];
    logic [ROOT_REM_BITS-1:0] cr_rem_reg [ROOT_BITS];
    logic [ROOT_X_BITS-1:0]   cr_x_reg   [ROOT_BITS];
    logic [IN_BITS-1:0]       cr_fmag_reg [ROOT_BITS][NUM_GRAD];
    logic                     cr_fneg_reg [ROOT_BITS][NUM_GRAD];

    // divider stages
    logic [ROOT_BITS-1:0] dv_r_reg   [NUM_BITS];
    logic [ROOT_BITS-1:0] dv_rem_reg [NUM_BITS][NUM_GRAD];
    logic [NUM_BITS-1:0]  dv_nq_reg  [NUM_BITS][NUM_GRAD];
    logic                 dv_neg_reg [NUM_BITS][NUM_GRAD];

    // invariants
    logic signed [G_BITS-1:0]      g_reg [NUM_GRAD];
    logic signed [PROD_G_BITS-1:0] cprod [NUM_PAIRS][3];
    logic signed [CS_BITS-1:0]     c_sum [NUM_PAIRS];
    logic signed [C_BITS-1:0]      c_reg [NUM_PAIRS];
    logic signed [I1_BITS-1:0]     i1_now;
    logic signed [I1_BITS-1:0]     i1_dly_reg [MUL_LAT];
    logic signed [2*C_BITS-1:0]    mprod [NUM_PAIRS];
    logic signed [P_BITS-1:0]      p_sum;
    logic signed [P_BITS-1:0]      p_reg;
    logic signed [I1_BITS-1:0]     i1_reg;
    logic signed [P_BITS-1:0]      i2m3;
    logic signed [P_BITS-1:0]      i2_cap;
    logic signed [I2C_BITS-1:0]    i2c_reg;
    logic signed [I1_BITS-1:0]     i1m3_reg;

    // energy
    logic signed [T1_BITS-1:0]  t1;
    logic signed [T2_BITS-1:0]  t2;
    logic signed [W_BITS-1:0]   w_sum;
    logic signed [W_BITS-1:0]   w_shift;
    logic signed [OUT_BITS-1:0] energy_next;
    logic signed [OUT_BITS-1:0] energy_reg;

    // busy only during and right after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;
    assign accept    = start && !busy_reg;

    // configuration registers; unknown indexes are dropped
    always_comb
    begin
        coef_first_next  = coef_first_reg;
        coef_second_next = coef_second_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COEF_FIRST:  coef_first_next  = cfg_data;
                REG_COEF_SECOND: coef_second_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_first_reg  <= '0;
            coef_second_reg <= '0;
            vld_reg         <= '0;
        end
        else
        begin
            coef_first_reg  <= coef_first_next;
            coef_second_reg <= coef_second_next;
            vld_reg         <= {vld_reg[LAT-2:0], accept};
        end
    end

    // zero-volume flag travels beside the valid bit
    always_ff @(posedge clk)
    begin
        zero_reg <= {zero_reg[LAT-2:0], request.volume_ratio == '0};
    end

    // input stage: magnitudes, signs and the cube-root radicand
    assign grad_in[0] = request.grad_xx;
    assign grad_in[1] = request.grad_xy;
    assign grad_in[2] = request.grad_xz;
    assign grad_in[3] = request.grad_yx;
    assign grad_in[4] = request.grad_yy;
    assign grad_in[5] = request.grad_yz;
    assign grad_in[6] = request.grad_zx;
    assign grad_in[7] = request.grad_zy;
    assign grad_in[8] = request.grad_zz;

    assign j_mag = request.volume_ratio[IN_BITS-1]
                 ? (IN_BITS'(~request.volume_ratio) + IN_BITS'(1))
                 : IN_BITS'(request.volume_ratio);

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NUM_GRAD; l++)
        begin
            in_fneg_reg[l] <= grad_in[l][IN_BITS-1];
            in_fmag_reg[l] <= grad_in[l][IN_BITS-1]
                            ? (IN_BITS'(~grad_in[l]) + IN_BITS'(1))
                            : IN_BITS'(grad_in[l]);
        end
        in_x_reg <= ROOT_X_BITS'(j_mag) << (2 * FRAC_BITS);
    end

    // cube root, one result bit per stage:
    // y doubles, trial = 3*(y^2 + y) + 1 against the remainder
    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_root
        logic [ROOT_BITS-1:0]     y_in, y2;
        logic [ROOT_SQ_BITS-1:0]  s_in, s4, ys;
        logic [ROOT_REM_BITS-1:0] rem_in, remx, trial;
        logic [ROOT_X_BITS-1:0]   x_in;
        logic [IN_BITS-1:0]       fmag_in [NUM_GRAD];
        logic                     fneg_in [NUM_GRAD];

        if (k == 0)
        begin : g_first
            assign y_in    = '0;
            assign s_in    = '0;
            assign rem_in  = '0;
            assign x_in    = in_x_reg;
            assign fmag_in = in_fmag_reg;
            assign fneg_in = in_fneg_reg;
        end
        else
        begin : g_next
            assign y_in    = cr_y_reg[k-1];
            assign s_in    = cr_s_reg[k-1];
            assign rem_in  = cr_rem_reg[k-1];
            assign x_in    = cr_x_reg[k-1];
            assign fmag_in = cr_fmag_reg[k-1];
            assign fneg_in = cr_fneg_reg[k-1];
        end

        always_comb
        begin
            y2    = y_in << 1;
            s4    = s_in << 2;
            ys    = s4 + ROOT_SQ_BITS'(y2);
            remx  = {rem_in[ROOT_REM_BITS-4:0], x_in[ROOT_X_BITS-1 -: 3]};
            trial = (ROOT_REM_BITS'(ys) << 1) + ROOT_REM_BITS'(ys) + ROOT_REM_BITS'(1);
        end

        always_ff @(posedge clk)
        begin
            if (remx >= trial)
            begin
                cr_rem_reg[k] <= remx - trial;
                cr_y_reg[k]   <= y2 | ROOT_BITS'(1);
                cr_s_reg[k]   <= s4 + (ROOT_SQ_BITS'(y2) << 1) + ROOT_SQ_BITS'(1);
            end
            else
            begin
                cr_rem_reg[k] <= remx;
                cr_y_reg[k]   <= y2;
                cr_s_reg[k]   <= s4;
            end
            cr_x_reg[k]    <= x_in << 3;
            cr_fmag_reg[k] <= fmag_in;
            cr_fneg_reg[k] <= fneg_in;
        end
    end

    // restoring dividers, one quotient bit per stage in nine lanes
    for (genvar d = 0; d < NUM_BITS; d++)
    begin : g_div
        logic [ROOT_BITS-1:0] r_in;

        if (d == 0)
        begin : g_first
            assign r_in = (cr_y_reg[ROOT_BITS-1] == '0) ? ROOT_BITS'(1)
                                                        : cr_y_reg[ROOT_BITS-1];
        end
        else
        begin : g_next
            assign r_in = dv_r_reg[d-1];
        end

        always_ff @(posedge clk)
        begin
            dv_r_reg[d] <= r_in;
        end

        for (genvar l = 0; l < NUM_GRAD; l++)
        begin : g_lane
            logic [ROOT_BITS-1:0] rem_in;
            logic [NUM_BITS-1:0]  nq_in;
            logic                 neg_in;
            logic [ROOT_BITS:0]   rx;

            if (d == 0)
            begin : g_first
                assign rem_in = '0;
                assign nq_in  = NUM_BITS'(cr_fmag_reg[ROOT_BITS-1][l]) << FRAC_BITS;
                assign neg_in = cr_fneg_reg[ROOT_BITS-1][l];
            end
            else
            begin : g_next
                assign rem_in = dv_rem_reg[d-1][l];
                assign nq_in  = dv_nq_reg[d-1][l];
                assign neg_in = dv_neg_reg[d-1][l];
            end

            assign rx = {rem_in, nq_in[NUM_BITS-1]};

            always_ff @(posedge clk)
            begin
                if (rx >= {1'b0, r_in})
                begin
                    dv_rem_reg[d][l] <= ROOT_BITS'(rx - {1'b0, r_in});
                    dv_nq_reg[d][l]  <= {nq_in[NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_reg[d][l] <= rx[ROOT_BITS-1:0];
                    dv_nq_reg[d][l]  <= {nq_in[NUM_BITS-2:0], 1'b0};
                end
                dv_neg_reg[d][l] <= neg_in;
            end
        end
    end

    // isochoric gradient with sign restored
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NUM_GRAD; l++)
        begin
            g_reg[l] <= dv_neg_reg[NUM_BITS-1][l]
                      ? (G_BITS'(0) - G_BITS'(dv_nq_reg[NUM_BITS-1][l]))
                      : G_BITS'(dv_nq_reg[NUM_BITS-1][l]);
        end
    end

    // C = G^T G: column dot products, upper triangle only
    for (genvar p = 0; p < NUM_PAIRS; p++)
    begin : g_cpair
        for (genvar k = 0; k < 3; k++)
        begin : g_term
            mre_mul #(
                .A_BITS (G_BITS),
                .B_BITS (G_BITS)
            ) u_gmul (
                .clk (clk),
                .a   (g_reg[3*k + PAIR_ROW[p]]),
                .b   (g_reg[3*k + PAIR_COL[p]]),
                .p   (cprod[p][k])
            );
        end
    end

    always_comb
    begin
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            c_sum[p] = CS_BITS'(cprod[p][0]) + CS_BITS'(cprod[p][1])
                     + CS_BITS'(cprod[p][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            c_reg[p] <= C_BITS'(c_sum[p] >>> FRAC_BITS);
        end
    end

    // I1 = trace, delayed to meet the minor products
    assign i1_now = I1_BITS'(c_reg[0]) + I1_BITS'(c_reg[3]) + I1_BITS'(c_reg[5]);

    always_ff @(posedge clk)
    begin
        i1_dly_reg[0] <= i1_now;
        for (int i = 1; i < MUL_LAT; i++)
        begin
            i1_dly_reg[i] <= i1_dly_reg[i-1];
        end
    end

    // principal 2x2 minors of C
    for (genvar q = 0; q < NUM_PAIRS; q++)
    begin : g_minor
        mre_mul #(
            .A_BITS (C_BITS),
            .B_BITS (C_BITS)
        ) u_cmul (
            .clk (clk),
            .a   (c_reg[MINOR_A[q]]),
            .b   (c_reg[MINOR_B[q]]),
            .p   (mprod[q])
        );
    end

    always_comb
    begin
        p_sum = '0;
        for (int q = 0; q < NUM_PAIRS; q++)
        begin
            if ((q % 2) == 0)
            begin
                p_sum = p_sum + P_BITS'(mprod[q]);
            end
            else
            begin
                p_sum = p_sum - P_BITS'(mprod[q]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= p_sum;
        i1_reg <= i1_dly_reg[MUL_LAT-1];
    end

    // I2 - 3 with its cap, I1 - 3
    always_comb
    begin
        i2m3 = (p_reg >>> FRAC_BITS) - THREE_P;
        if (i2m3 < CAP_LO)
        begin
            i2_cap = CAP_LO;
        end
        else if (i2m3 > CAP_HI)
        begin
            i2_cap = CAP_HI;
        end
        else
        begin
            i2_cap = i2m3;
        end
    end

    always_ff @(posedge clk)
    begin
        i2c_reg  <= I2C_BITS'(i2_cap);
        i1m3_reg <= i1_reg - THREE_I1;
    end

    // coefficient terms
    mre_mul #(
        .A_BITS (COEF_BITS),
        .B_BITS (I1_BITS)
    ) u_t1_mul (
        .clk (clk),
        .a   ($signed(coef_first_reg)),
        .b   (i1m3_reg),
        .p   (t1)
    );

    mre_mul #(
        .A_BITS (COEF_BITS),
        .B_BITS (I2C_BITS)
    ) u_t2_mul (
        .clk (clk),
        .a   ($signed(coef_second_reg)),
        .b   (i2c_reg),
        .p   (t2)
    );

    // final scale, saturation and zero-volume override
    always_comb
    begin
        w_sum   = W_BITS'(t1) + W_BITS'(t2);
        w_shift = w_sum >>> FRAC_BITS;
        if (zero_reg[LAT-2])
        begin
            energy_next = '0;
        end
        else if (w_shift > OUT_MAX)
        begin
            energy_next = OUT_BITS'(OUT_MAX);
        end
        else if (w_shift < OUT_MIN)
        begin
            energy_next = OUT_BITS'(OUT_MIN);
        end
        else
        begin
            energy_next = OUT_BITS'(w_shift);
        end
    end

    always_ff @(posedge clk)
    begin
        energy_reg <= energy_next;
    end

    assign result_valid          = vld_reg[LAT-1];
    assign result.energy_density = energy_reg;
    assign result.zero_volume    = zero_reg[LAT-1];

endmodule

FILE: rtl/mre_check.sv
// Port-level checker for the energy unit, bound to the top level.
`include "assert_macros.svh"

module mre_check
    import mre_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input mre_request_t             request,
    input logic                     result_valid,
    input mre_result_t              result
);

    localparam int LAT = pipe_latency(FRAC_BITS);

    logic req_taken;
    logic zero_taken;

    assign req_taken  = start && !busy;
    assign zero_taken = req_taken && (request.volume_ratio == '0);

    // every request yields a result after the fixed latency
    `ASSERT_IMPLIES(a_req_result, clk, rst_n, req_taken, ##LAT result_valid, "result missing")

    // no result without a request that far back
    `ASSERT_IMPLIES(a_no_phantom, clk, rst_n, result_valid, $past(req_taken, LAT), "unexpected result")

    // zero J is flagged on its own result
    `ASSERT_IMPLIES(a_zero_flag, clk, rst_n, zero_taken, ##LAT result.zero_volume, "zero J not flagged")

    // a flagged result carries zero energy
    `ASSERT_IMPLIES(a_zero_energy, clk, rst_n, result_valid && result.zero_volume, result.energy_density == '0, "energy not forced to zero")

endmodule

bind mooney_rivlin_energy_unit mre_check #(.FRAC_BITS(FRAC_BITS)) u_mre_check (.*);
